/* design/fdr_pkg.sv */
// Package: shared constants and sideband type for the Fresnel reflectance pipeline.
package fdr_pkg;

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 30;

  localparam logic [14:0] ETA_OUT_RST = 15'd4096;
  localparam logic [14:0] ETA_IN_RST  = 15'd5461;

  localparam logic CFG_ETA_OUT = 1'b0;
  localparam logic CFG_ETA_IN  = 1'b1;

  localparam logic [16:0] REFL_ONE = 17'd65536;

  typedef struct packed {
    logic        tir;
    logic [14:0] cm;
    logic [14:0] ei;
    logic [14:0] et;
    logic [29:0] sin_t;
  } side_t;

endpackage

/* design/fdr_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module fdr_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [60:0]     in_val,
  input  fdr_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [30:0]     out_root,
  output fdr_pkg::side_t  out_side
);

  localparam int N = fdr_pkg::SQ_STEPS;

  logic [60:0]    val_r  [1:N];
  logic [61:0]    root_r [1:N];
  logic           vld_r  [1:N];
  fdr_pkg::side_t side_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - j));
    logic [60:0]    vin, val_nxt;
    logic [61:0]    rin, trial, root_nxt;
    logic           vldin;
    fdr_pkg::side_t sin;

    if (j == 0) begin : g_first
      assign vin   = in_val;
      assign rin   = '0;
      assign vldin = in_valid;
      assign sin   = in_side;
    end else begin : g_rest
      assign vin   = val_r[j];
      assign rin   = root_r[j];
      assign vldin = vld_r[j];
      assign sin   = side_r[j];
    end

    assign trial = rin + BIT;

    always_comb begin
      if ({1'b0, vin} >= trial) begin
        val_nxt  = vin - trial[60:0];
        root_nxt = (rin >> 1) + BIT;
      end else begin
        val_nxt  = vin;
        root_nxt = rin >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vldin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[j+1]  <= val_nxt;
        root_r[j+1] <= root_nxt;
        side_r[j+1] <= sin;
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_root  = root_r[N][30:0];
  assign out_side  = side_r[N];

endmodule

/* design/fdr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module fdr_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_num,
  input  logic [46:0]     in_den,
  input  fdr_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [29:0]     out_quot,
  output fdr_pkg::side_t  out_side
);

  localparam int N = fdr_pkg::DIV_STEPS;

  logic [63:0]    rem_r  [1:N];
  logic [46:0]    den_r  [1:N];
  logic [29:0]    quot_r [1:N];
  logic           vld_r  [1:N];
  fdr_pkg::side_t side_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam int K = N - 1 - j;
    logic [63:0]    rin, rem_nxt;
    logic [46:0]    din;
    logic [29:0]    qin, quot_nxt;
    logic [75:0]    dsh;
    logic           vldin;
    fdr_pkg::side_t sin;

    if (j == 0) begin : g_first
      assign rin   = in_num;
      assign din   = in_den;
      assign qin   = '0;
      assign vldin = in_valid;
      assign sin   = in_side;
    end else begin : g_rest
      assign rin   = rem_r[j];
      assign din   = den_r[j];
      assign qin   = quot_r[j];
      assign vldin = vld_r[j];
      assign sin   = side_r[j];
    end

    assign dsh = {29'd0, din} << K;

    always_comb begin
      if ({12'd0, rin} >= dsh) begin
        rem_nxt  = rin - dsh[63:0];
        quot_nxt = qin | (30'd1 << K);
      end else begin
        rem_nxt  = rin;
        quot_nxt = qin;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vldin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= rem_nxt;
        den_r[j+1]  <= din;
        quot_r[j+1] <= quot_nxt;
        side_r[j+1] <= sin;
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_quot  = quot_r[N];
  assign out_side  = side_r[N];

endmodule

/* design/fresnel_dielectric_reflectance.sv */
// Top level: pipelined unpolarized Fresnel reflectance of a dielectric boundary.
//
// channel  dir  handshake        payload
// in_      in   tvalid/tready    tdata[15:0] cos_incident (Q1.14 signed)
// out_     out  tvalid/tready    tdata[16:0] reflectance, tuser[0] total_internal
// cfg_     in   we               index 0 eta_outside, 1 eta_inside (Q3.12)
//
// One transaction per cycle sustained while out_tready stays high; the datapath holds two
// 31-stage square roots and two 30-stage dividers in series.
// Synchronous active-low reset clears valid bits and loads the index registers.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module fresnel_dielectric_reflectance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] cos_incident
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] reflectance, rest zero
  output logic        out_tuser,  // [0] total_internal
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  logic        en;
  logic [14:0] eta_out_r, eta_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_out_r <= fdr_pkg::ETA_OUT_RST;
      eta_in_r  <= fdr_pkg::ETA_IN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdr_pkg::CFG_ETA_OUT: eta_out_r <= cfg_data;
        fdr_pkg::CFG_ETA_IN:  eta_in_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 0: clamp, swap, 1 - c^2
  logic signed [15:0] c_in, c_cl;
  logic [15:0]        c_mag;
  logic               c_neg;
  logic [29:0]        c_sq;
  logic [28:0]        a_nxt;
  fdr_pkg::side_t     side0_nxt, side0_r;
  logic [60:0]        v0_r;
  logic               vld0_r;

  always_comb begin
    c_in = in_tdata;
    if (c_in > 16'sd16384) begin
      c_cl = 16'sd16384;
    end else if (c_in < -16'sd16384) begin
      c_cl = -16'sd16384;
    end else begin
      c_cl = c_in;
    end
    c_neg = (c_cl <= 16'sd0);
    c_mag = c_neg ? 16'(-c_cl) : 16'(c_cl);
    c_sq  = 30'(c_mag[14:0]) * 30'(c_mag[14:0]);
    a_nxt = 29'h1000_0000 - c_sq[28:0];
    side0_nxt.tir   = 1'b0;
    side0_nxt.cm    = c_mag[14:0];
    side0_nxt.ei    = c_neg ? eta_in_r  : eta_out_r;
    side0_nxt.et    = c_neg ? eta_out_r : eta_in_r;
    side0_nxt.sin_t = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r    <= {a_nxt, 32'd0};
      side0_r <= side0_nxt;
    end
  end

  // sin_i
  logic           vld1;
  logic [30:0]    sin_i;
  fdr_pkg::side_t side1;

  fdr_isqrt u_sqrt_sin (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld0_r), .in_val(v0_r), .in_side(side0_r),
    .out_valid(vld1), .out_root(sin_i), .out_side(side1)
  );

  // stage 2: eta_i * sin_i
  logic [45:0]    num2_r;
  fdr_pkg::side_t side2_r;
  logic           vld2_r;

  // stage 3: TIR test
  logic [63:0]    num3_r;
  logic [46:0]    den3_r;
  fdr_pkg::side_t side3_r, side3_nxt;
  logic           vld3_r;

  always_comb begin
    side3_nxt     = side2_r;
    side3_nxt.tir = (side2_r.et == 15'd0) || (num2_r >= {1'b0, side2_r.et, 30'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r  <= 46'(side1.ei) * 46'(sin_i);
      side2_r <= side1;
      num3_r  <= {18'd0, num2_r};
      den3_r  <= side3_nxt.tir ? 47'd1 : {32'd0, side2_r.et};
      side3_r <= side3_nxt;
    end
  end

  // sin_t
  logic           vld4;
  logic [29:0]    sin_t;
  fdr_pkg::side_t side4;

  fdr_div u_div_sin (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld3_r), .in_num(num3_r), .in_den(den3_r), .in_side(side3_r),
    .out_valid(vld4), .out_quot(sin_t), .out_side(side4)
  );

  // stage 5: sin_t^2, stage 6: 1 - sin_t^2
  logic [59:0]    sq5_r;
  logic [60:0]    v6_r;
  fdr_pkg::side_t side5_nxt, side5_r, side6_r;
  logic           vld5_r, vld6_r;

  always_comb begin
    side5_nxt       = side4;
    side5_nxt.sin_t = sin_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld4;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5_r   <= 60'(sin_t) * 60'(sin_t);
      side5_r <= side5_nxt;
      v6_r    <= (61'd1 << 60) - {1'b0, sq5_r};
      side6_r <= side5_r;
    end
  end

  // cos_t
  logic           vld7;
  logic [30:0]    cos_t;
  fdr_pkg::side_t side7;

  fdr_isqrt u_sqrt_cos (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld6_r), .in_val(v6_r), .in_side(side6_r),
    .out_valid(vld7), .out_root(cos_t), .out_side(side7)
  );

  // stage 8: products, stage 9: sum/diff, stage 10: dividend
  logic [30:0]    cos_i30;
  logic [45:0]    xp8_r, yp8_r, xq8_r, yq8_r;
  logic [46:0]    sp9_r, sq9_r;
  logic [45:0]    dp9_r, dq9_r;
  logic [63:0]    nump_r, numq_r;
  logic [46:0]    denp_r, denq_r;
  fdr_pkg::side_t side8_r, side9_r, side10_r;
  logic           vld8_r, vld9_r, vld10_r;

  assign cos_i30 = {side7.cm, 16'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld8_r  <= 1'b0;
      vld9_r  <= 1'b0;
      vld10_r <= 1'b0;
    end else if (en) begin
      vld8_r  <= vld7;
      vld9_r  <= vld8_r;
      vld10_r <= vld9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp8_r    <= 46'(side7.et) * 46'(cos_i30);
      yp8_r    <= 46'(side7.ei) * 46'(cos_t);
      xq8_r    <= 46'(side7.ei) * 46'(cos_i30);
      yq8_r    <= 46'(side7.et) * 46'(cos_t);
      side8_r  <= side7;
      sp9_r    <= {1'b0, xp8_r} + {1'b0, yp8_r};
      sq9_r    <= {1'b0, xq8_r} + {1'b0, yq8_r};
      dp9_r    <= (xp8_r > yp8_r) ? xp8_r - yp8_r : yp8_r - xp8_r;
      dq9_r    <= (xq8_r > yq8_r) ? xq8_r - yq8_r : yq8_r - xq8_r;
      side9_r  <= side8_r;
      nump_r   <= (sp9_r == '0) ? 64'd262144 : ({dp9_r, 18'd0} + {18'd0, sp9_r[46:1]});
      numq_r   <= (sq9_r == '0) ? 64'd262144 : ({dq9_r, 18'd0} + {18'd0, sq9_r[46:1]});
      denp_r   <= (sp9_r == '0) ? 47'd1 : sp9_r;
      denq_r   <= (sq9_r == '0) ? 47'd1 : sq9_r;
      side10_r <= side9_r;
    end
  end

  // ratios
  logic           vld11, vld11q;
  logic [29:0]    p_q, q_q;
  fdr_pkg::side_t side11, side11q;

  fdr_div u_div_p (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld10_r), .in_num(nump_r), .in_den(denp_r), .in_side(side10_r),
    .out_valid(vld11), .out_quot(p_q), .out_side(side11)
  );

  fdr_div u_div_q (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld10_r), .in_num(numq_r), .in_den(denq_r), .in_side(side10_r),
    .out_valid(vld11q), .out_quot(q_q), .out_side(side11q)
  );

  // stage 12: squares, stage 13: output register
  logic [37:0] pp12_r, qq12_r;
  logic        tir12_r, vld12_r;
  logic [38:0] sum13;
  logic [17:0] refl13;
  logic [16:0] refl_r;
  logic        tir_r;

  always_comb begin
    sum13  = {1'b0, pp12_r} + {1'b0, qq12_r} + 39'd1048576;
    refl13 = sum13[38:21];
    if (tir12_r || refl13 > {1'b0, fdr_pkg::REFL_ONE}) begin
      refl13 = {1'b0, fdr_pkg::REFL_ONE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld12_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld12_r     <= vld11 && vld11q;
      out_valid_r <= vld12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp12_r  <= 38'(p_q[18:0]) * 38'(p_q[18:0]);
      qq12_r  <= 38'(q_q[18:0]) * 38'(q_q[18:0]);
      tir12_r <= side11.tir || side11q.tir;
      refl_r  <= refl13[16:0];
      tir_r   <= tir12_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, refl_r};
  assign out_tuser  = tir_r;

endmodule

/* test/fresnel_dielectric_reflectance_test.sv */
// Testbench: checks the Fresnel reflectance pipeline against a bit-true predictor.
module fresnel_dielectric_reflectance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 132;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = fdr_pkg::CFG_ETA_OUT;
  logic [14:0] cfg_data = '0;

  typedef struct {
    logic [16:0] reflectance;
    logic        total_internal;
  } refl_t;

  refl_t refl_q[$];
  logic [14:0] eta_out_m = fdr_pkg::ETA_OUT_RST;
  logic [14:0] eta_in_m = fdr_pkg::ETA_IN_RST;
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_tir = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stall_on = 1'b1;

  fresnel_dielectric_reflectance dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] ratio_q18(logic [63:0] x, logic [63:0] y);
    logic [63:0] s, d;
    s = x + y;
    d = (x > y) ? x - y : y - x;
    if (s == 0) return 64'd1 << 18;
    return ((d << 18) + (s >> 1)) / s;
  endfunction

  function automatic refl_t fresnel_predict(logic [15:0] raw);
    refl_t r;
    int c;
    logic [63:0] ei, et, tmp, cm, si, st, ct, ci, p, q, sum;
    c = $signed(raw);
    ei = eta_out_m;
    et = eta_in_m;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (c <= 0) begin
      tmp = ei; ei = et; et = tmp; c = -c;
    end
    cm = c;
    r.reflectance = fdr_pkg::REFL_ONE;
    r.total_internal = 1'b1;
    if (et == 0) return r;
    si = int_sqrt(((64'd1 << 28) - cm * cm) << 32);
    st = (ei * si) / et;
    if (st >= (64'd1 << 30)) return r;
    ct = int_sqrt((64'd1 << 60) - st * st);
    ci = cm << 16;
    p = ratio_q18(et * ci, ei * ct);
    q = ratio_q18(ei * ci, et * ct);
    sum = (p * p + q * q + (64'd1 << 20)) >> 21;
    if (sum > fdr_pkg::REFL_ONE) sum = fdr_pkg::REFL_ONE;
    r.reflectance = sum[16:0];
    r.total_internal = 1'b0;
    return r;
  endfunction

  // input transaction: predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      refl_q.push_back(fresnel_predict(in_tdata));
      n_sent++;
    end
  end

  // result check
  always @(posedge clk) begin
    refl_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_recv++;
      if (refl_q.size() == 0) begin
        $error("unexpected result reflectance=%0d", out_tdata[16:0]);
        errors++;
      end else begin
        e = refl_q.pop_front();
        if (out_tdata[16:0] !== e.reflectance) begin
          $error("reflectance exp %0d got %0d", e.reflectance, out_tdata[16:0]);
          errors++;
        end
        if (out_tuser !== e.total_internal) begin
          $error("total_internal exp %0b got %0b", e.total_internal, out_tuser);
          errors++;
        end
        if (e.total_internal) n_tir++;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int k;
    if (long_hold) out_tready <= 1'b0;
    else if (!stall_on) out_tready <= 1'b1;
    else begin
      k = $urandom_range(0, 15);
      out_tready <= (k > 4) || (k == 0 && out_tready);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_cos(logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (refl_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_eta(logic idx, logic [14:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fdr_pkg::CFG_ETA_OUT) eta_out_m = v;
    else eta_in_m = v;
  endtask

  function automatic logic [15:0] rand_cos();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'($signed($urandom_range(0, 400)) - 200);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  task automatic test_directed();
    logic [15:0] pts[] = '{16'sd16384, -16'sd16384, 16'd0, 16'sd1, -16'sd1,
      16'sd16385, -16'sd16385, 16'h7fff, 16'h8000, 16'sd8192, -16'sd8192,
      16'sd100, -16'sd100, 16'sd16383, -16'sd16383, 16'h5555, 16'haaaa,
      16'sd3000, -16'sd3000, 16'sd12000};
    foreach (pts[i]) send_cos(pts[i]);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_cos(rand_cos());
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (250) send_cos(rand_cos());
    join
    drain();
  endtask

  task automatic test_eta_settings();
    logic [14:0] set_o[] = '{15'd1024, 15'd16384, 15'd16384, 15'd1024, 15'd4096, 15'h7fff,
      15'd0, 15'd4096};
    logic [14:0] set_i[] = '{15'd16384, 15'd1024, 15'd16384, 15'd1024, 15'd4096, 15'd0,
      15'h7fff, 15'd4096};
    foreach (set_o[i]) begin
      write_eta(fdr_pkg::CFG_ETA_OUT, set_o[i]);
      write_eta(fdr_pkg::CFG_ETA_IN, set_i[i]);
      stall_on = (i % 3) != 2;
      send_cos(16'sd16384);
      send_cos(-16'sd16384);
      send_cos(16'd0);
      test_random(25);
    end
    stall_on = 1'b1;
    write_eta(fdr_pkg::CFG_ETA_OUT, fdr_pkg::ETA_OUT_RST);
    write_eta(fdr_pkg::CFG_ETA_IN, fdr_pkg::ETA_IN_RST);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(60);
    test_backpressure();
    test_eta_settings();
    $display("Sent %0d cosines, checked %0d reflectances (%0d total internal)",
             n_sent, n_recv, n_tir);
    $display("across reset, extreme and swapped index settings, with stalls and backpressure");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* filelist.f */
design/fdr_pkg.sv
design/fdr_isqrt.sv
design/fdr_div.sv
design/fresnel_dielectric_reflectance.sv
test/fresnel_dielectric_reflectance_test.sv
